// ----- src/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg: shared definitions for the synchronous serial port
// Register offsets, request kinds, status bit positions and reset values.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Default FIFO depth, in 16-bit words.
  localparam int unsigned FIFO_DEPTH_DEF = 16;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Word offsets of the bus registers.
  localparam logic [13:0] REG_CTRL0  = 14'd0;
  localparam logic [13:0] REG_CTRL1  = 14'd1;
  localparam logic [13:0] REG_STATUS = 14'd2;
  localparam logic [13:0] REG_DATA   = 14'd4;

  // Status register bit positions.
  localparam int unsigned ST_TNF  = 2;   // transmit not full
  localparam int unsigned ST_RNE  = 3;   // receive not empty
  localparam int unsigned ST_BSY  = 4;   // busy
  localparam int unsigned ST_TFS  = 5;   // transmit at or below threshold
  localparam int unsigned ST_RFS  = 6;   // receive level above threshold
  localparam int unsigned ST_ROR  = 7;   // receive overrun
  localparam int unsigned ST_TFL  = 8;   // transmit level, 4 bits
  localparam int unsigned ST_RFL  = 12;  // receive level minus one, 4 bits

  localparam logic [15:0] STATUS_RESET = 16'h0024;

  // Control one bit positions.
  localparam int unsigned C1_RIE   = 0;
  localparam int unsigned C1_TIE   = 1;
  localparam int unsigned C1_LBM   = 2;
  localparam int unsigned C1_TFT   = 6;   // transmit threshold, 4 bits
  localparam int unsigned C1_RFT   = 10;  // receive threshold, 4 bits

  // Result word shown on the output stream.
  typedef struct packed {
    logic [4:0]  word_bits;
    logic [15:0] tx_word;
    logic        tx_valid;
    logic        busy_res;
    logic        dma_tx_req;
    logic        dma_rx_req;
    logic        irq;
    logic        access_ok;
    logic [31:0] rdata;
  } result_t;

endpackage

// ----- src/ssp_serial_port_fifo_top.sv -----
// ----------------------------------------------------------------------------
// ssp_serial_port_fifo_top: synchronous serial port with transmit/receive FIFOs
// Bus register file, two ring FIFOs and the transfer tick, one request a cycle while results are taken.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream is a bus read, a bus write or a transfer
// tick, selected by s_axis_tuser_i. Every request produces exactly one result
// on the master stream, in order. The result carries the read data, the decode
// flag, the interrupt and DMA lines, the busy bit and, for a tick, the word
// shifted out to the serial partner together with the frame size.
// The work for a request is done in the cycle it is accepted, so its result
// appears on the master stream in the cycle after. A new request can be accepted
// every cycle; the rate is one request per cycle, set by the single result
// register. When the receiver stalls, the held result stays in the result
// register and new requests are refused until that result is taken.
// Reset clears the control registers, empties both FIFOs, sets the status
// register to transmit-not-full and transmit-below-threshold and raises the
// transmit DMA request. FIFO storage is not cleared; only written entries
// are ever read.
module ssp_serial_port_fifo_top #(
  parameter int unsigned FIFO_DEPTH = ssp_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [13:0] reg_index, [45:14] wdata, [61:46] partner_reply, [63:62] zero
  input  logic [63:0] s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] rdata, [32] access_ok, [33] irq, [34] dma_rx_req, [35] dma_tx_req,
  // [36] busy_res, [37] tx_valid, [53:38] tx_word, [58:54] word_bits,
  // [63:59] zero
  output logic [63:0] m_axis_tdata_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);

  // Ring pointer advance with wrap at the FIFO depth.
  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrLast) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Request fields.
  ssp_pkg::op_e op;
  logic [13:0]  reg_index;
  logic [31:0]  wdata;
  logic [15:0]  partner_reply;

  assign op            = ssp_pkg::op_e'(s_axis_tuser_i);
  assign reg_index     = s_axis_tdata_i[13:0];
  assign wdata         = s_axis_tdata_i[45:14];
  assign partner_reply = s_axis_tdata_i[61:46];

  // Architectural state.
  logic [31:0]     ctrl0_q, ctrl0_d;
  logic [31:0]     ctrl1_q, ctrl1_d;
  logic [15:0]     status_q, status_d;
  logic [CntW-1:0] tx_cnt_q, tx_cnt_d, rx_cnt_q, rx_cnt_d;
  logic [PtrW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [PtrW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic            irq_q, irq_d;
  logic            rx_req_q, rx_req_d;
  logic            tx_req_q, tx_req_d;

  // FIFO storage: written at the tail, read at the head.
  logic [15:0] tx_mem [FIFO_DEPTH];
  logic [15:0] rx_mem [FIFO_DEPTH];
  logic        tx_we, rx_we;
  logic [15:0] tx_wdata, rx_wdata;

  // Result register.
  logic              out_valid_q;
  ssp_pkg::result_t  out_q, res;

  logic accept;
  logic tx_chg, rx_chg;
  logic [4:0] tx_lvl, rx_lvl;

  // The result register frees up when its word is taken in the same cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign tx_lvl = 5'(tx_cnt_d);
  assign rx_lvl = 5'(rx_cnt_d) - 5'd1;

  always_comb begin
    ctrl0_d   = ctrl0_q;
    ctrl1_d   = ctrl1_q;
    status_d  = status_q;
    tx_cnt_d  = tx_cnt_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    irq_d     = irq_q;
    rx_req_d  = rx_req_q;
    tx_req_d  = tx_req_q;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    tx_wdata  = wdata[15:0];
    rx_wdata  = partner_reply;
    tx_chg    = 1'b0;
    rx_chg    = 1'b0;
    res       = '0;

    unique case (op)
      ssp_pkg::OP_READ, ssp_pkg::OP_WRITE: begin
        res.access_ok = 1'b1;
        unique case (reg_index)
          ssp_pkg::REG_CTRL0: begin
            if (op == ssp_pkg::OP_WRITE) begin
              ctrl0_d = wdata;
            end else begin
              res.rdata = ctrl0_q;
            end
          end
          ssp_pkg::REG_CTRL1: begin
            if (op == ssp_pkg::OP_WRITE) begin
              ctrl1_d = wdata;
            end else begin
              res.rdata = ctrl1_q;
            end
          end
          ssp_pkg::REG_STATUS: begin
            if (op == ssp_pkg::OP_WRITE) begin
              status_d[ssp_pkg::ST_ROR] = wdata[ssp_pkg::ST_ROR];
            end else begin
              res.rdata = {16'd0, status_q};
            end
          end
          ssp_pkg::REG_DATA: begin
            if (op == ssp_pkg::OP_WRITE) begin
              // A write to a full transmit FIFO is dropped.
              if (tx_cnt_q != CntFull) begin
                status_d[ssp_pkg::ST_BSY] = 1'b1;
                tx_we     = 1'b1;
                tx_tail_d = ptr_next(tx_tail_q);
                tx_cnt_d  = tx_cnt_q + 1'b1;
                tx_chg    = 1'b1;
              end
            end else if (rx_cnt_q != '0) begin
              res.rdata = {16'd0, rx_mem[rx_head_q]};
              rx_head_d = ptr_next(rx_head_q);
              rx_cnt_d  = rx_cnt_q - 1'b1;
              rx_chg    = 1'b1;
            end
          end
          default: begin
            res.access_ok = 1'b0;
          end
        endcase
      end
      ssp_pkg::OP_TICK: begin
        if (tx_cnt_q == '0) begin
          status_d[ssp_pkg::ST_BSY] = 1'b0;
        end else begin
          res.tx_valid = 1'b1;
          res.tx_word  = tx_mem[tx_head_q];
          tx_head_d    = ptr_next(tx_head_q);
          tx_cnt_d     = tx_cnt_q - 1'b1;
          tx_chg       = 1'b1;
          if (ctrl1_q[ssp_pkg::C1_LBM]) begin
            rx_wdata = tx_mem[tx_head_q];
          end
          // With the receive FIFO full the word is lost and overrun is flagged.
          if (rx_cnt_q == CntFull) begin
            status_d[ssp_pkg::ST_ROR] = 1'b1;
          end else begin
            rx_we     = 1'b1;
            rx_tail_d = ptr_next(rx_tail_q);
            rx_cnt_d  = rx_cnt_q + 1'b1;
            rx_chg    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // Level, threshold, DMA and interrupt lines follow only FIFO changes.
    if (tx_chg) begin
      status_d[ssp_pkg::ST_TNF] = (tx_cnt_d != CntFull);
      status_d[ssp_pkg::ST_TFL +: 4] = tx_lvl[3:0];
      status_d[ssp_pkg::ST_TFS] = (tx_lvl <= {1'b0, ctrl1_q[ssp_pkg::C1_TFT +: 4]});
      tx_req_d = status_d[ssp_pkg::ST_TFS];
    end
    if (rx_chg) begin
      status_d[ssp_pkg::ST_RNE] = (rx_cnt_d != '0);
      status_d[ssp_pkg::ST_RFL +: 4] = rx_lvl[3:0];
      status_d[ssp_pkg::ST_RFS] =
        (5'(rx_cnt_d) > {1'b0, ctrl1_q[ssp_pkg::C1_RFT +: 4]});
      rx_req_d = status_d[ssp_pkg::ST_RFS];
    end
    if (tx_chg || rx_chg) begin
      irq_d = (status_d[ssp_pkg::ST_RFS] && ctrl1_q[ssp_pkg::C1_RIE]) ||
              (status_d[ssp_pkg::ST_TFS] && ctrl1_q[ssp_pkg::C1_TIE]);
    end

    res.irq        = irq_d;
    res.dma_rx_req = rx_req_d;
    res.dma_tx_req = tx_req_d;
    res.busy_res   = status_d[ssp_pkg::ST_BSY];
    res.word_bits  = 5'd1 + {1'b0, ctrl0_d[3:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q   <= '0;
      ctrl1_q   <= '0;
      status_q  <= ssp_pkg::STATUS_RESET;
      tx_cnt_q  <= '0;
      rx_cnt_q  <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      irq_q     <= 1'b0;
      rx_req_q  <= 1'b0;
      tx_req_q  <= 1'b1;
    end else if (accept) begin
      ctrl0_q   <= ctrl0_d;
      ctrl1_q   <= ctrl1_d;
      status_q  <= status_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      irq_q     <= irq_d;
      rx_req_q  <= rx_req_d;
      tx_req_q  <= tx_req_d;
    end
  end

  // FIFO storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept && tx_we) begin
      tx_mem[tx_tail_q] <= tx_wdata;
    end
    if (accept && rx_we) begin
      rx_mem[rx_tail_q] <= rx_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

endmodule
